// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/kbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kbp_pkg;

    // pool size default
    localparam int DEFAULT_CAPACITY = 30;

    // field widths
    localparam int DIM_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EVICT  = 2'd3;

    // input transaction
    typedef struct packed {
        logic                opcode;
        logic [DIM_W-1:0]    req_width;
        logic [DIM_W-1:0]    req_height;
        logic [HANDLE_W-1:0] in_texture;
        logic [HANDLE_W-1:0] in_target;
    } in_item_t;

    // output transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] out_texture;
        logic [HANDLE_W-1:0] out_target;
    } out_item_t;

    // one pool entry
    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [HANDLE_W-1:0] texture;
        logic [HANDLE_W-1:0] target;
    } entry_t;

    // per-cell update control
    typedef struct packed {
        logic upd;
        logic acquire;
        logic full;
        logic load_here;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/keyed_buffer_pool_fifo_evict_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyed buffer pool: holds up to CAPACITY released (texture, target) handle
// pairs, keyed by width and height, oldest first in a row of cells. An
// acquire returns and removes the oldest entry with the same key (status
// hit) or reports a miss with zero handles; a release appends the entry and,
// when the pool was full, evicts the oldest entry and returns its handles.
// One result per transaction. When a transaction is accepted, every cell
// compares its key and registers the match; in S_UPDATE the hit ripples
// down the cell chain, the cells shift or load, and the result enters the
// output register. The block then returns to S_IDLE and accepts the next
// transaction; it takes no new transaction while one is in progress. A
// stalled result that still holds the output register delays the update
// until it is taken.
module keyed_buffer_pool_fifo_evict_top
    import kbp_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire in_item_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output out_item_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    in_item_t         item_reg;
    logic             rsp_valid_reg;
    out_item_t        rsp_reg;
    out_item_t        result;

    logic             req_fire;
    logic             upd;
    logic             full;
    logic             acquire;
    entry_t           new_entry;
    logic [HANDLE_W-1:0] hit_texture;
    logic [HANDLE_W-1:0] hit_target;

    logic   [CAPACITY:0]   hit_chain;
    logic   [CAPACITY-1:0] sel;
    entry_t                entries [CAPACITY];

    // handshake
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid & ~req_stall;
    assign upd       = (state_reg == S_UPDATE) & (~rsp_valid_reg | ~rsp_stall);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign acquire   = (item_reg.opcode == OP_ACQUIRE);

    assign new_entry.width   = item_reg.req_width;
    assign new_entry.height  = item_reg.req_height;
    assign new_entry.texture = item_reg.in_texture;
    assign new_entry.target  = item_reg.in_target;

    assign hit_chain[0] = 1'b0;

    // row of cells, index 0 holds the oldest entry
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     next_entry;

        assign ctrl.upd       = upd;
        assign ctrl.acquire   = acquire;
        assign ctrl.full      = full;
        assign ctrl.load_here = ~full & (count_reg == CNT_W'(i));

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = new_entry;
        end
        else
        begin : g_body
            assign next_entry = entries[i+1];
        end

        kbp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmp_en     (req_fire),
            .key_width  (req.req_width),
            .key_height (req.req_height),
            .occupied   (CNT_W'(i) < count_reg),
            .hit_in     (hit_chain[i]),
            .next_entry (next_entry),
            .new_entry  (new_entry),
            .ctrl       (ctrl),
            .hit_out    (hit_chain[i+1]),
            .sel        (sel[i]),
            .entry      (entries[i])
        );
    end

    // gather handles of the selected cell
    always_comb
    begin
        hit_texture = '0;
        hit_target  = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            hit_texture = hit_texture | (sel[k] ? entries[k].texture : '0);
            hit_target  = hit_target  | (sel[k] ? entries[k].target  : '0);
        end
    end

    // result and next count
    always_comb
    begin
        result     = '0;
        count_next = count_reg;
        if (acquire)
        begin
            if (hit_chain[CAPACITY])
            begin
                result.status      = ST_HIT;
                result.out_texture = hit_texture;
                result.out_target  = hit_target;
                count_next         = count_reg - CNT_W'(1);
            end
            else
            begin
                result.status = ST_MISS;
            end
        end
        else if (full)
        begin
            result.status      = ST_EVICT;
            result.out_texture = entries[0].texture;
            result.out_target  = entries[0].target;
        end
        else
        begin
            result.status = ST_STORED;
            count_next    = count_reg + CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (upd)
                    begin
                        state_reg <= S_IDLE;
                        count_reg <= count_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (upd)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req;
        end
        if (upd)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/kbp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kbp_cell
    import kbp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmp_en,
    input  wire logic [DIM_W-1:0] key_width,
    input  wire logic [DIM_W-1:0] key_height,
    input  wire logic             occupied,
    input  wire logic             hit_in,
    input  wire entry_t           next_entry,
    input  wire entry_t           new_entry,
    input  wire cell_ctrl_t       ctrl,
    output logic                  hit_out,
    output logic                  sel,
    output entry_t                entry
);

    logic   match_reg;
    logic   match_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   shift;
    logic   load;

    // key compare, captured when the transaction is accepted
    always_comb
    begin
        match_next = match_reg;
        if (cmp_en)
        begin
            match_next = occupied && (entry_reg.width == key_width)
                         && (entry_reg.height == key_height);
        end
    end

    // first match in the chain owns the result
    assign hit_out = hit_in | match_reg;
    assign sel     = match_reg & ~hit_in;

    // shift from younger neighbor or load the released entry
    assign shift = ctrl.upd & (ctrl.acquire ? hit_out : ctrl.full);
    assign load  = ctrl.upd & ~ctrl.acquire & ctrl.load_here;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = next_entry;
        end
        else if (load)
        begin
            entry_next = new_entry;
        end
    end

    // match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: hw/rtl/kbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kbp_checker
    import kbp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_stall,
    input wire in_item_t  req,
    input wire logic      rsp_valid,
    input wire logic      rsp_stall,
    input wire out_item_t rsp
);

    // a stalled result holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // block is busy right after taking a transaction
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    // a miss carries no handles
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, rsp_valid && (rsp.status == ST_MISS), (rsp.out_texture == '0) && (rsp.out_target == '0))

    // a plain store carries no handles
    `ASSERT_IMPLY(a_store_zero, clk, rst_n, rsp_valid && (rsp.status == ST_STORED), (rsp.out_texture == '0) && (rsp.out_target == '0))

endmodule

bind keyed_buffer_pool_fifo_evict_top kbp_checker u_kbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
